### rtl/assert_macros.svh
// Assertion macros shared by the time mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ON(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rs) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ASSERT_ON(lbl, ck, rs, prop, msg)
`define ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

### rtl/atm_pkg.sv
// Shared constants and sideband types of the animation time mapper.
package atm_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_STEP      = 2;
  localparam int ITER_W        = 16;
  localparam int CFG_IDX_W     = 3;

  localparam longint unsigned SIMPLE_DUR_RST = 64'd65536;
  localparam longint unsigned ACTIVE_DUR_RST = 64'd99999;

  localparam int ITER_POS_LIM = 32767;
  localparam int ITER_NEG_LIM = 32768;
  localparam logic signed [ITER_W-1:0] ITER_MAX = 16'sh7fff;
  localparam logic signed [ITER_W-1:0] ITER_MIN = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_DUR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DUR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_REV   = 3'd5;

  typedef struct packed {
    logic neg;
    logic frac;
    logic dz;
  } d1_side_t;

  typedef struct packed {
    logic                     c2;
    logic                     dz;
    logic signed [ITER_W-1:0] iter;
  } d2_side_t;

endpackage

### rtl/animation_time_mapper.sv
// Animation time mapper: speed scaling, period wrap, auto-reverse and easing.
// Throughput is one item per cycle while busy is low; the two pipelined dividers set the latency.
// Results appear on out_valid for one cycle and cannot be held off.
// Reset is synchronous: pipeline valids clear, registers take their defaults,
// and busy is high while reset is applied.
`include "assert_macros.svh"
module animation_time_mapper #(
  parameter int TIME_BITS = atm_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = atm_pkg::FRAC_BITS_DEF,
  localparam int CFG_W = (TIME_BITS > FRAC_BITS + 9) ? TIME_BITS : FRAC_BITS + 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [TIME_BITS-1:0]              in_active_time,
  output logic                              out_valid,
  output logic [TIME_BITS-1:0]              out_filtered_time,
  output logic signed [atm_pkg::ITER_W-1:0] out_iteration,
  input  logic                              cfg_we,
  input  logic [atm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]                  cfg_wdata
);
  import atm_pkg::*;

  localparam int T     = TIME_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SPD_W = F + 9;
  localparam int RAT_W = F + 1;
  localparam int X_W   = T + SPD_W;
  localparam int FL_W  = X_W - F;
  localparam int P_W   = T + 1;
  localparam int AD_W  = T + RAT_W;
  localparam int K_W   = F + 2;
  localparam int ADK_W = AD_W + K_W;
  localparam int SQ_W  = 2 * T;
  localparam int N2_W  = 2 * T + 2 * F;
  localparam int Q2_W  = T + 2;
  localparam int N1ST  = (FL_W + DIV_STEP - 1) / DIV_STEP;
  localparam int N2ST  = (Q2_W + DIV_STEP - 1) / DIV_STEP;
  localparam int LAT   = 8 + N1ST + N2ST;

  // Configuration registers.
  logic [T-1:0]     sd_r, adur_r;
  logic [SPD_W-1:0] spd_r;
  logic [RAT_W-1:0] acc_r, dec_r;
  logic             ar_r;
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r   <= T'(SIMPLE_DUR_RST);
      adur_r <= T'(ACTIVE_DUR_RST);
      spd_r  <= SPD_W'(1) << F;
      acc_r  <= '0;
      dec_r  <= '0;
      ar_r   <= 1'b0;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_SIMPLE_DUR: sd_r   <= cfg_wdata[T-1:0];
          REG_ACTIVE_DUR: adur_r <= cfg_wdata[T-1:0];
          REG_SPEED:      spd_r  <= cfg_wdata[SPD_W-1:0];
          REG_ACCEL:      acc_r  <= cfg_wdata[RAT_W-1:0];
          REG_DECEL:      dec_r  <= cfg_wdata[RAT_W-1:0];
          REG_AUTO_REV:   ar_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // Values derived from configuration; they settle through registered ratio, product and
  // scaled-product steps, well before an item reaches the stages that use them.
  logic [P_W-1:0]   p_r, p_nxt;
  logic [SPD_W-1:0] mag_r, mag_nxt;
  logic             sub_r, sub_nxt;
  logic [RAT_W-1:0] ae_r, ee_r, ae_nxt, ee_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [AD_W-1:0]  ad_r, ed_r, ad_nxt, ed_nxt;
  logic [ADK_W-1:0] adk_r, edk_r, adk_nxt, edk_nxt;
  logic [RAT_W:0]   rsum;

  always_comb begin
    p_nxt   = ar_r ? {sd_r, 1'b0} : {1'b0, sd_r};
    mag_nxt = spd_r[SPD_W-1] ? (SPD_W'(0) - spd_r) : spd_r;
    sub_nxt = spd_r[SPD_W-1] || (spd_r == '0);
    rsum    = {1'b0, acc_r} + {1'b0, dec_r};
    // Ratios that add up to more than one are both dropped.
    if (rsum > ((RAT_W+1)'(1) << F)) begin
      ae_nxt = '0;
      ee_nxt = '0;
    end else begin
      ae_nxt = acc_r;
      ee_nxt = dec_r;
    end
    k_nxt   = (K_W'(1) << (F + 1)) - K_W'(ae_nxt) - K_W'(ee_nxt);
    ad_nxt  = ae_r * sd_r;
    ed_nxt  = ee_r * sd_r;
    adk_nxt = ad_r * k_r;
    edk_nxt = ed_r * k_r;
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    mag_r <= mag_nxt;
    sub_r <= sub_nxt;
    ae_r  <= ae_nxt;
    ee_r  <= ee_nxt;
    k_r   <= k_nxt;
    ad_r  <= ad_nxt;
    ed_r  <= ed_nxt;
    adk_r <= adk_nxt;
    edk_r <= edk_nxt;
  end

  // Stages 0 to 2: capture, speed product, origin and whole-tick split.
  logic             s0_valid_r, s1_valid_r, s2_valid_r;
  logic [T-1:0]     tau_r;
  logic [X_W-1:0]   x_r, x_nxt, v_nxt, adf;
  logic             neg_nxt;
  logic [FL_W-1:0]  fl_r;
  logic             frac_r, neg_r, dz2_r;

  always_comb begin
    x_nxt   = tau_r * mag_r;
    adf     = X_W'({adur_r, {F{1'b0}}});
    neg_nxt = 1'b0;
    if (!sub_r) begin
      v_nxt = x_r;
    end else if (adf >= x_r) begin
      v_nxt = adf - x_r;
    end else begin
      v_nxt   = x_r - adf;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy_r;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
    tau_r  <= in_active_time;
    x_r    <= x_nxt;
    fl_r   <= v_nxt[X_W-1:F];
    frac_r <= |v_nxt[F-1:0];
    neg_r  <= neg_nxt;
    dz2_r  <= (sd_r == '0);
  end

  // Whole ticks over the period: quotient is the iteration, remainder the phase.
  d1_side_t        d1_in_side, d1_side;
  logic            d1_valid;
  logic [FL_W-1:0] d1_quo;
  logic [P_W-1:0]  d1_rem;

  assign d1_in_side = '{neg: neg_r, frac: frac_r, dz: dz2_r};

  atm_div #(
    .NUM_W (FL_W),
    .DEN_W (P_W),
    .QUO_W (FL_W),
    .STEP  (DIV_STEP),
    .SIDE_W($bits(d1_side_t))
  ) u_div_period (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid_r),
    .in_num   (fl_r),
    .in_den   (p_r),
    .in_side  (d1_in_side),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_side (d1_side)
  );

  // Stage 3: iteration saturation and floored remainder.
  logic                     s3_valid_r, dz3_r;
  logic signed [ITER_W-1:0] iter3_r, iter3_nxt;
  logic [P_W-1:0]           tsu_r, tsu_nxt;
  logic [P_W:0]             cm;

  always_comb begin
    if (!d1_side.neg) begin
      iter3_nxt = (d1_quo > FL_W'(ITER_POS_LIM)) ? ITER_MAX : d1_quo[ITER_W-1:0];
    end else begin
      iter3_nxt = (d1_quo > FL_W'(ITER_NEG_LIM)) ? ITER_MIN
                                                  : ITER_W'(0) - d1_quo[ITER_W-1:0];
    end
    // A negative time with a fractional part rounds one tick further down.
    cm = {1'b0, d1_rem} + (P_W+1)'(d1_side.frac);
    if (cm >= {1'b0, p_r}) begin
      cm = '0;
    end
    if (!d1_side.neg) begin
      tsu_nxt = d1_rem;
    end else if (cm == '0) begin
      tsu_nxt = '0;
    end else begin
      tsu_nxt = p_r - cm[P_W-1:0];
    end
  end

  // Stages 4 to 6: mirror, segment choice, square.
  logic                     s4_valid_r, s5_valid_r, s6_valid_r;
  logic                     dz4_r, dz5_r, dz6_r;
  logic signed [ITER_W-1:0] iter4_r, iter5_r, iter6_r;
  logic [T-1:0]             t4_r, t4_nxt, t5_r, u5_r, sq_base;
  logic                     c1_5_r, c1_6_r, c2_6_r, c1_nxt, c2_nxt;
  logic [SQ_W-1:0]          sq6_r, sq_nxt;
  logic [AD_W-1:0]          n3_r, n3_nxt;

  always_comb begin
    t4_nxt  = (ar_r && tsu_r >= {1'b0, sd_r}) ? T'(p_r - tsu_r) : T'(tsu_r);
    c1_nxt  = AD_W'({t4_r, {F{1'b0}}}) < ad_r;
    c2_nxt  = !c1_5_r && (AD_W'({u5_r, {F{1'b0}}}) < ed_r);
    sq_base = c1_5_r ? t5_r : u5_r;
    sq_nxt  = sq_base * sq_base;
    n3_nxt  = {t5_r, {(F+1){1'b0}}} - ad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= d1_valid;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
    iter3_r <= iter3_nxt;
    tsu_r   <= tsu_nxt;
    dz3_r   <= d1_side.dz;
    iter4_r <= iter3_r;
    t4_r    <= t4_nxt;
    dz4_r   <= dz3_r;
    iter5_r <= iter4_r;
    t5_r    <= t4_r;
    u5_r    <= sd_r - t4_r;
    c1_5_r  <= c1_nxt;
    dz5_r   <= dz4_r;
    iter6_r <= iter5_r;
    sq6_r   <= sq_nxt;
    n3_r    <= n3_nxt;
    c1_6_r  <= c1_5_r;
    c2_6_r  <= c2_nxt;
    dz6_r   <= dz5_r;
  end

  // Easing division: quadratic ramps or the linear run-rate segment.
  logic [N2_W-1:0]  num2;
  logic [ADK_W-1:0] den2;
  d2_side_t         d2_in_side, d2_side;
  logic             d2_valid;
  logic [Q2_W-1:0]  d2_quo;
  logic [ADK_W-1:0] d2_rem;

  always_comb begin
    num2 = (c1_6_r || c2_6_r) ? {sq6_r, {(2*F){1'b0}}} : N2_W'(n3_r);
    if (c1_6_r) begin
      den2 = adk_r;
    end else if (c2_6_r) begin
      den2 = edk_r;
    end else begin
      den2 = ADK_W'(k_r);
    end
  end

  assign d2_in_side = '{c2: c2_6_r, dz: dz6_r, iter: iter6_r};

  atm_div #(
    .NUM_W (N2_W),
    .DEN_W (ADK_W),
    .QUO_W (Q2_W),
    .STEP  (DIV_STEP),
    .SIDE_W($bits(d2_side_t))
  ) u_div_ease (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s6_valid_r),
    .in_num   (num2),
    .in_den   (den2),
    .in_side  (d2_in_side),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_rem  (d2_rem),
    .out_side (d2_side)
  );

  // Output stage: deceleration rounds up and counts back from the duration.
  logic                     out_valid_r;
  logic [T-1:0]             ft_r, ft_nxt;
  logic signed [ITER_W-1:0] it_r, it_nxt;
  logic [Q2_W:0]            cc, tsf;

  always_comb begin
    cc = {1'b0, d2_quo} + (Q2_W+1)'(|d2_rem);
    if (!d2_side.c2) begin
      tsf = {1'b0, d2_quo};
    end else if (cc > (Q2_W+1)'(sd_r)) begin
      tsf = '0;
    end else begin
      tsf = (Q2_W+1)'(sd_r) - cc;
    end
    if (d2_side.dz) begin
      ft_nxt = '0;
      it_nxt = '0;
    end else begin
      ft_nxt = (tsf > (Q2_W+1)'({T{1'b1}})) ? {T{1'b1}} : tsf[T-1:0];
      it_nxt = d2_side.iter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_valid;
    end
    ft_r <= ft_nxt;
    it_r <= it_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_filtered_time = ft_r;
  assign out_iteration     = it_r;

  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid && busy, "reset left a result or dropped busy")
  `ASSERT_ON(a_latency, clk, rst_n, start && !busy |-> ##LAT out_valid, "accepted transfer produced no result")
  `ASSERT_ON(a_zero_dur, clk, rst_n, d2_valid && d2_side.dz |=> out_valid && out_filtered_time == '0 && out_iteration == '0, "zero duration gave a non-zero result")

endmodule

### rtl/atm_div.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`include "assert_macros.svh"
module atm_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 8,
  parameter int STEP   = atm_pkg::DIV_STEP,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);
  localparam int NST = (QUO_W + STEP - 1) / STEP;
  localparam int QP  = NST * STEP;

  logic              valid_r [NST];
  logic [DEN_W-1:0]  rem_r   [NST];
  logic [DEN_W-1:0]  den_r   [NST];
  logic [QP-1:0]     low_r   [NST];
  logic [QP-1:0]     quo_r   [NST];
  logic [SIDE_W-1:0] side_r  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic              src_valid;
    logic [DEN_W-1:0]  src_rem;
    logic [DEN_W-1:0]  src_den;
    logic [QP-1:0]     src_low;
    logic [QP-1:0]     src_quo;
    logic [SIDE_W-1:0] src_side;
    logic [DEN_W-1:0]  rem_nxt;
    logic [QP-1:0]     low_nxt;
    logic [QP-1:0]     quo_nxt;

    if (s == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_den   = in_den;
      assign src_quo   = '0;
      assign src_side  = in_side;
      // Dividend bits above the quotient range form the starting remainder.
      if (NUM_W > QP) begin : g_hi
        assign src_rem = DEN_W'(in_num[NUM_W-1:QP]);
        assign src_low = in_num[QP-1:0];
      end else begin : g_lo
        assign src_rem = '0;
        assign src_low = QP'(in_num);
      end
    end else begin : g_next
      assign src_valid = valid_r[s-1];
      assign src_rem   = rem_r[s-1];
      assign src_den   = den_r[s-1];
      assign src_low   = low_r[s-1];
      assign src_quo   = quo_r[s-1];
      assign src_side  = side_r[s-1];
    end

    always_comb begin : p_step
      logic [DEN_W:0] part;
      rem_nxt = src_rem;
      low_nxt = src_low;
      quo_nxt = src_quo;
      part    = '0;
      for (int i = 0; i < STEP; i++) begin
        part    = {rem_nxt, low_nxt[QP-1]};
        low_nxt = low_nxt << 1;
        if (part >= {1'b0, src_den}) begin
          part    = part - {1'b0, src_den};
          quo_nxt = {quo_nxt[QP-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QP-2:0], 1'b0};
        end
        rem_nxt = part[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else begin
        valid_r[s] <= src_valid;
      end
      rem_r[s]  <= rem_nxt;
      den_r[s]  <= src_den;
      low_r[s]  <= low_nxt;
      quo_r[s]  <= quo_nxt;
      side_r[s] <= src_side;
    end
  end

  assign out_valid = valid_r[NST-1];
  assign out_quo   = quo_r[NST-1][QUO_W-1:0];
  assign out_rem   = rem_r[NST-1];
  assign out_side  = side_r[NST-1];

  `ASSERT_ALWAYS(a_div_rst_clear, clk, !rst_n |=> !out_valid, "divider valid survived reset")
  `ASSERT_ON(a_div_latency, clk, rst_n, in_valid |-> ##NST out_valid, "divider lost a transfer")
  `ASSERT_ON(a_div_zero, clk, rst_n, in_valid && in_num == '0 && in_den != '0 |-> ##NST out_quo == '0 && out_rem == '0, "zero dividend gave a non-zero result")

endmodule

### verif/testbench.sv
// Self-checking testbench for the animation time mapper: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import atm_pkg::*;

  typedef bit [191:0] wide_t;

  localparam int TB = 32;
  localparam int LATENCY = 46;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [63:0] TMAX = 64'hFFFF_FFFF;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  logic [TB-1:0] in_active_time, out_filtered_time, cfg_wdata;
  logic signed [ITER_W-1:0] out_iteration;
  logic [CFG_IDX_W-1:0] cfg_index;

  animation_time_mapper dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_active_time(in_active_time), .out_valid(out_valid),
    .out_filtered_time(out_filtered_time), .out_iteration(out_iteration),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [TB-1:0]     ftime;
    logic [ITER_W-1:0] iter;
  } mapped_t;

  // Directed row: either a register write or an item, optionally with a typed result.
  typedef struct {
    bit                is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [TB-1:0]     val;
    bit                typed;
    logic [TB-1:0]     ftime;
    logic [ITER_W-1:0] iter;
  } row_t;

  mapped_t pending_maps[$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_idle = 0;
  bit row_typed = 0;
  mapped_t row_result;

  // Shadow copy of the registers.
  logic [63:0] m_dur, m_act;
  logic [24:0] m_speed;
  logic [16:0] m_acc, m_dec;
  logic        m_rev;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic mapped_t map_time(input logic [TB-1:0] tau);
    mapped_t r;
    wide_t d, p, mag, x, v, q, fl, m, tsu, t, a, e, k, ad, ed, num, u, c, tsf, one;
    bit sneg, neg, frac;
    one = 65536;
    d = m_dur;
    neg = 0;
    if (d == 0) begin
      r.ftime = 0;
      r.iter = 0;
      return r;
    end
    p = m_rev ? 2 * d : d;
    sneg = m_speed[24];
    mag = sneg ? (wide_t'(1) << 25) - m_speed : m_speed;
    x = wide_t'(tau) * mag;
    if (!sneg && m_speed != 0) begin
      v = x;
    end else if ((wide_t'(m_act) << 16) >= x) begin
      v = (wide_t'(m_act) << 16) - x;
    end else begin
      v = x - (wide_t'(m_act) << 16);
      neg = 1;
    end
    q = v / (p << 16);
    if (!neg) r.iter = q > 32767 ? 16'h7fff : q[15:0];
    else r.iter = q > 32768 ? 16'h8000 : 16'(17'h10000 - q[16:0]);
    fl = v >> 16;
    frac = v[15:0] != 0;
    m = fl % p;
    if (!neg) begin
      tsu = m;
    end else begin
      c = m + frac;
      if (c >= p) c = 0;
      tsu = c != 0 ? p - c : 0;
    end
    t = (m_rev && tsu >= d) ? p - tsu : tsu;
    a = m_acc;
    e = m_dec;
    if (a + e > one) begin
      a = 0;
      e = 0;
    end
    k = 2 * one - a - e;
    ad = a * d;
    ed = e * d;
    u = d - t;
    if ((t << 16) < ad) begin
      tsf = ((t * t) << 32) / (ad * k);
    end else if ((u << 16) < ed) begin
      num = (u * u) << 32;
      c = num / (ed * k) + ((num % (ed * k)) != 0);
      tsf = c > d ? 0 : d - c;
    end else begin
      tsf = ((t << 17) - ad) / k;
    end
    r.ftime = tsf > TMAX ? TMAX[TB-1:0] : tsf[TB-1:0];
    return r;
  endfunction

  // Input transfers, register writes, result checks and the watchdog share one edge.
  always @(posedge clk) begin
    mapped_t want;
    bit moved;
    if (rst_n) begin
      moved = (start && !busy) || out_valid || cfg_we;
      if (start && !busy) begin
        pending_maps.insert(pending_maps.size(),
                            row_typed ? row_result : map_time(in_active_time));
      end
      if (out_valid) begin
        if (pending_maps.size() == 0) begin
          $display("%0t: unexpected result ftime=%h iter=%h", $realtime,
                   out_filtered_time, out_iteration);
          errors++;
        end else begin
          want = pending_maps.pop_front();
          if (want.ftime !== out_filtered_time) begin
            $display("%0t: filtered_time expected %h actual %h", $realtime,
                     want.ftime, out_filtered_time);
            errors++;
          end
          if (want.iter !== out_iteration) begin
            $display("%0t: iteration expected %h actual %h", $realtime,
                     want.iter, out_iteration);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIMPLE_DUR: m_dur <= cfg_wdata;
          REG_ACTIVE_DUR: m_act <= cfg_wdata;
          REG_SPEED:      m_speed <= cfg_wdata[24:0];
          REG_ACCEL:      m_acc <= cfg_wdata[16:0];
          REG_DECEL:      m_dec <= cfg_wdata[16:0];
          REG_AUTO_REV:   m_rev <= cfg_wdata[0];
          default: ;
        endcase
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** animation_time_mapper: FAILED **");
        $finish;
      end
    end else begin
      m_dur <= SIMPLE_DUR_RST;
      m_act <= ACTIVE_DUR_RST;
      m_speed <= 25'h10000;
      m_acc <= '0;
      m_dec <= '0;
      m_rev <= 1'b0;
    end
  end

  task automatic drain();
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TB-1:0] val);
    @(negedge clk);
    start = 0;
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send(input logic [TB-1:0] tau, input bit typed, input mapped_t res);
    while ($urandom_range(99) < sender_idle) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    start = 1;
    in_active_time = tau;
    row_typed = typed;
    row_result = res;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [TB-1:0] pick_time();
    case ($urandom_range(5))
      0: return $urandom_range(255);
      1: return 32'hFFFF_FFFF - $urandom_range(255);
      2: return $urandom_range(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_settings();
    logic [TB-1:0] dur, spd, acc, dec;
    case ($urandom_range(6))
      0: dur = 1;
      1: dur = 32'hFFFF_FFFF;
      2: dur = $urandom_range(16);
      3: dur = $urandom_range(1 << 12);
      4: dur = 0;
      default: dur = $urandom;
    endcase
    case ($urandom_range(6))
      0: spd = 32'h00FF_FFFF;
      1: spd = 32'h0100_0000;
      2: spd = 0;
      3: spd = 32'h01FF_0000 | $urandom_range(65535);
      4: spd = $urandom_range(1 << 18);
      default: spd = $urandom;
    endcase
    acc = $urandom_range(3) == 0 ? 0 : $urandom_range(65536);
    dec = $urandom_range(3) == 0 ? 65536 - acc : $urandom_range(65536);
    write_reg(REG_SIMPLE_DUR, dur);
    write_reg(REG_ACTIVE_DUR, $urandom_range(1) ? $urandom : $urandom_range(1 << 20));
    write_reg(REG_SPEED, spd);
    write_reg(REG_ACCEL, acc);
    write_reg(REG_DECEL, dec);
    write_reg(REG_AUTO_REV, $urandom_range(1));
  endtask

  function automatic row_t item(input logic [TB-1:0] tau);
    row_t r;
    r = '{default: 0};
    r.val = tau;
    return r;
  endfunction

  function automatic row_t known(input logic [TB-1:0] tau, input logic [TB-1:0] ft,
                                 input logic [ITER_W-1:0] it);
    row_t r;
    r = '{is_reg: 0, idx: 0, val: tau, typed: 1, ftime: ft, iter: it};
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [TB-1:0] val);
    row_t r;
    r = '{default: 0};
    r.is_reg = 1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  row_t steps[$];
  int idle_mix[4] = '{0, 51, 0, 22};

  initial begin
    mapped_t res;
    rst_n = 0;
    start = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    in_active_time = 0;
    res = '{default: 0};
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Values after reset, then each special case in turn.
    steps = '{
      known(0, 0, 0), known(65536, 0, 1), known(32'hFFFF_FFFF, 65535, ITER_MAX),
      item(12345),
      reg_row(REG_SPEED, 32'h01FF_0000), item(0), item(99999), item(32'hFFFF_FFFF),
      reg_row(REG_SPEED, 0), item(7),
      reg_row(REG_SPEED, 32'h0100_0000), item(32'hFFFF_FFFF),
      reg_row(REG_SPEED, 32'h00FF_FFFF), reg_row(REG_AUTO_REV, 1), item(70000),
      item(32'hFFFF_FFFF),
      reg_row(REG_ACCEL, 16384), reg_row(REG_DECEL, 16384), item(5000), item(60000),
      item(30000),
      reg_row(REG_ACCEL, 65536), item(5000),
      reg_row(REG_SIMPLE_DUR, 0), known(12345, 0, 0),
      reg_row(REG_SIMPLE_DUR, 32'hFFFF_FFFF), reg_row(REG_ACTIVE_DUR, 32'hFFFF_FFFF),
      reg_row(REG_DECEL, 0), item(32'hFFFF_FFFF), item(1)
    };
    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        @(negedge clk);
        start = 0;
        drain();
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        res.ftime = steps[i].ftime;
        res.iter = steps[i].iter;
        send(steps[i].val, steps[i].typed, res);
      end
    end

    res = '{default: 0};
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle = idle_mix[ph];
      for (int s = 0; s < 4; s++) begin
        @(negedge clk);
        start = 0;
        drain();
        random_settings();
        for (int n = 0; n < 50; n++) send(pick_time(), 0, res);
      end
    end
    @(negedge clk);
    start = 0;
    drain();
    if (errors == 0) begin
      $display("** animation_time_mapper: PASSED **");
    end else begin
      $display("** animation_time_mapper: FAILED **");
    end
    $finish;
  end
endmodule
